### rtl/spl_pkg.sv
`timescale 1ns / 1ps
package spl_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int OP_W     = 2;
  localparam int PRI_W    = 8;
  localparam int TAG_W    = 16;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;
  localparam int EPOS_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_LIST = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE          = 3'd0,
    STS_ALREADY_EMPTY = 3'd1,
    STS_BAD_POS       = 3'd2,
    STS_FULL          = 3'd3,
    STS_ENTRY         = 3'd4,
    STS_EMPTY         = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_CMP,
    S_ADD_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_LIST_RD,
    S_LIST_EMIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [PRI_W-1:0] pri;
    logic [TAG_W-1:0] tag;
  } entry_t;

endpackage

### rtl/spl_in_if.sv
`timescale 1ns / 1ps
interface spl_in_if;
  logic                       valid;
  logic                       ready;
  logic [spl_pkg::OP_W-1:0]   op;
  logic [spl_pkg::PRI_W-1:0]  priority_req;
  logic [spl_pkg::TAG_W-1:0]  task_tag;
  logic [spl_pkg::POS_W-1:0]  position;

  modport source (output valid, op, priority_req, task_tag, position, input ready);
  modport sink (input valid, op, priority_req, task_tag, position, output ready);
endinterface

### rtl/spl_out_if.sv
`timescale 1ns / 1ps
interface spl_out_if;
  logic                          valid;
  logic                          ready;
  logic [spl_pkg::STATUS_W-1:0]  status;
  logic [spl_pkg::EPOS_W-1:0]    entry_position;
  logic [spl_pkg::PRI_W-1:0]     entry_priority;
  logic [spl_pkg::TAG_W-1:0]     entry_tag;
  logic                          last;

  modport source (output valid, status, entry_position, entry_priority, entry_tag, last,
                  input ready);
  modport sink (input valid, status, entry_position, entry_priority, entry_tag, last,
                output ready);
endinterface

### rtl/sorted_priority_list.sv
`timescale 1ns / 1ps
// Add: each entry with a greater priority is moved up one place, then the new entry is written.
// Delete: each entry above the deleted one is moved down one place; one beat out.
// List: one beat per entry, each read through the single read port of the entry memory.
// One beat is taken at a time; the next is taken once the last result is registered.
// Reset clears the sequencer, the entry count and the output valid flag; the entry
// memory is not cleared, as only entries below the count are ever read.
module sorted_priority_list #(
  parameter int MAX_ENTRIES = spl_pkg::MAX_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  spl_in_if.sink       in_ch,
  spl_out_if.source    out_ch
);
  import spl_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  status_t          sts_r, sts_nxt;
  logic [PRI_W-1:0] pri_r;
  logic [TAG_W-1:0] tag_r;

  entry_t           mem [MAX_ENTRIES];
  entry_t           rdata_r;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  entry_t           mem_wdata;

  logic             out_valid_r;
  status_t          out_sts_r;
  logic [EPOS_W-1:0] out_pos_r;
  entry_t           out_ent_r;
  logic             out_last_r;

  logic             out_free, in_acc, load_out, load_last;
  status_t          load_sts;
  logic [EPOS_W-1:0] load_pos;
  entry_t           load_ent;
  op_t              in_op;
  logic             full, empty, bad_pos;
  logic             list_last;

  assign in_op     = op_t'(in_ch.op);
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign full      = (count_r == CW'(MAX_ENTRIES));
  assign empty     = (count_r == '0);
  assign bad_pos   = (in_ch.position == '0) || (in_ch.position > POS_W'(count_r));
  assign list_last = (CW'(idx_r + 1'b1) == count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_ADD: begin
              if (full) state_nxt = S_RESP;
              else if (empty) state_nxt = S_ADD_PUT;
              else state_nxt = S_ADD_RD;
            end
            OP_DEL: begin
              if (empty || bad_pos) state_nxt = S_RESP;
              else if (POS_W'(count_r) == in_ch.position) state_nxt = S_RESP;
              else state_nxt = S_DEL_RD;
            end
            OP_LIST: begin
              if (empty) state_nxt = S_RESP;
              else state_nxt = S_LIST_RD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_RD: state_nxt = S_ADD_CMP;
      S_ADD_CMP: begin
        if (rdata_r.pri > pri_r) begin
          state_nxt = (idx_r == CW'(1)) ? S_ADD_PUT : S_ADD_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_ADD_PUT: state_nxt = S_RESP;
      S_DEL_RD: state_nxt = S_DEL_WR;
      S_DEL_WR: begin
        state_nxt = (CW'(idx_r + 2'd2) < count_r) ? S_DEL_RD : S_RESP;
      end
      S_LIST_RD: state_nxt = S_LIST_EMIT;
      S_LIST_EMIT: begin
        if (out_free) state_nxt = list_last ? S_IDLE : S_LIST_RD;
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    sts_nxt     = sts_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = idx_r[AW-1:0];
    mem_raddr   = idx_r[AW-1:0];
    mem_wdata   = '{pri: pri_r, tag: tag_r};
    load_out    = 1'b0;
    load_sts    = sts_r;
    load_pos    = '0;
    load_ent    = '0;
    load_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sts_nxt = STS_DONE;
          case (in_op)
            OP_ADD: begin
              idx_nxt = count_r;
              if (full) sts_nxt = STS_FULL;
            end
            OP_DEL: begin
              idx_nxt = CW'(in_ch.position - 1'b1);
              if (empty) sts_nxt = STS_ALREADY_EMPTY;
              else if (bad_pos) sts_nxt = STS_BAD_POS;
              else if (POS_W'(count_r) == in_ch.position) count_nxt = CW'(count_r - 1'b1);
            end
            OP_LIST: begin
              idx_nxt = '0;
              if (empty) sts_nxt = STS_EMPTY;
            end
            default: sts_nxt = sts_r;
          endcase
        end
      end
      S_ADD_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(idx_r - 1'b1);
      end
      S_ADD_CMP: begin
        mem_we = 1'b1;
        if (rdata_r.pri > pri_r) begin
          mem_wdata = rdata_r;
          idx_nxt   = CW'(idx_r - 1'b1);
        end else begin
          count_nxt = CW'(count_r + 1'b1);
        end
      end
      S_ADD_PUT: begin
        mem_we    = 1'b1;
        count_nxt = CW'(count_r + 1'b1);
      end
      S_DEL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(idx_r + 1'b1);
      end
      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_r;
        idx_nxt   = CW'(idx_r + 1'b1);
        if (!(CW'(idx_r + 2'd2) < count_r)) count_nxt = CW'(count_r - 1'b1);
      end
      S_LIST_RD: begin
        mem_re = 1'b1;
      end
      S_LIST_EMIT: begin
        if (out_free) begin
          load_out  = 1'b1;
          load_sts  = STS_ENTRY;
          load_pos  = EPOS_W'(idx_r + 1'b1);
          load_ent  = rdata_r;
          load_last = list_last;
          idx_nxt   = CW'(idx_r + 1'b1);
        end
      end
      S_RESP: begin
        load_out = out_free;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      sts_r       <= STS_DONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      sts_r   <= sts_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pri_r <= in_ch.priority_req;
      tag_r <= in_ch.task_tag;
    end
    if (load_out) begin
      out_sts_r  <= load_sts;
      out_pos_r  <= load_pos;
      out_ent_r  <= load_ent;
      out_last_r <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_sts_r;
  assign out_ch.entry_position = out_pos_r;
  assign out_ch.entry_priority = out_ent_r.pri;
  assign out_ch.entry_tag      = out_ent_r.tag;
  assign out_ch.last           = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_r == $past(count_r)) || (count_r == CW'($past(count_r) + 1'b1)) ||
        (count_r == CW'($past(count_r) - 1'b1)))
    else $error("entry count moved by more than one");

  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CW'(mem_waddr) < CW'(MAX_ENTRIES)))
    else $error("entry write outside list");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && load_last) |=> (state_r == S_IDLE))
    else $error("final beat loaded but sequencer still busy");

  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_acc)
    else $error("beat taken while busy");

endmodule
